// ===== src/b2da_pkg.sv =====
package b2da_pkg;

  // Width of the binary value on the input channel.
  localparam int VALUE_W = 16;
  // One decimal digit, 0 to 9.
  localparam int DIGIT_W = 4;
  // ASCII code of one digit character, 48 to 57.
  localparam int CHAR_W = 6;
  // Byte-padded widths of the stream data buses.
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;

  // Default number of decimal positions formed by the digit pipeline.
  localparam int MAX_DIGITS_DEF = 5;
  // A 16-bit value never needs more than five characters.
  localparam int MAX_RESULTS = 5;

  localparam int DEC_BASE = 10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

  // Division by ten through a reciprocal: q = (x * 52429) >> 19 is exact
  // for every 16-bit x.
  localparam int DIV10_MUL_W = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(52429);
  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W = VALUE_W + DIV10_MUL_W;
  localparam int QUOT_W = PROD_W - DIV10_SHIFT;

endpackage

// ===== src/b2da_digit_stage.sv =====
module b2da_digit_stage #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
  parameter int POS = 0
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               en,
  input  logic                                               in_valid,
  input  logic [b2da_pkg::VALUE_W-1:0]                       in_rest,
  input  logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0]       in_digits,
  output logic                                               out_valid,
  output logic [b2da_pkg::VALUE_W-1:0]                       out_rest,
  output logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0]       out_digits
);

  logic [b2da_pkg::PROD_W-1:0]                  prod;
  logic [b2da_pkg::QUOT_W-1:0]                  quot;
  logic [b2da_pkg::VALUE_W-1:0]                 quot_ext;
  logic [b2da_pkg::VALUE_W-1:0]                 quot_x10;
  logic [b2da_pkg::VALUE_W-1:0]                 rem;

  logic                                         valid_r;
  logic                                         valid_nxt;
  logic [b2da_pkg::VALUE_W-1:0]                 rest_r;
  logic [b2da_pkg::VALUE_W-1:0]                 rest_nxt;
  logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] digits_r;
  logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] digits_nxt;

  // Quotient by reciprocal multiply, remainder by shift-and-add of 10*q.
  assign prod     = b2da_pkg::PROD_W'(in_rest) * b2da_pkg::PROD_W'(b2da_pkg::DIV10_MUL);
  assign quot     = prod[b2da_pkg::PROD_W-1:b2da_pkg::DIV10_SHIFT];
  assign quot_ext = b2da_pkg::VALUE_W'(quot);
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem      = in_rest - quot_x10;

  always_comb begin
    valid_nxt  = valid_r;
    rest_nxt   = rest_r;
    digits_nxt = digits_r;
    if (en) begin
      valid_nxt       = in_valid;
      rest_nxt        = quot_ext;
      digits_nxt      = in_digits;
      digits_nxt[POS] = rem[b2da_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r   <= rest_nxt;
    digits_r <= digits_nxt;
  end

  assign out_valid  = valid_r;
  assign out_rest   = rest_r;
  assign out_digits = digits_r;

endmodule

// ===== src/b2da_serializer.sv =====
module b2da_serializer #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  input  logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] in_digits,
  output logic                                         in_ready,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [b2da_pkg::CHAR_W-1:0]                  out_char,
  output logic                                         out_tlast
);

  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic                                         busy_r;
  logic                                         busy_nxt;
  logic [IDX_W-1:0]                             idx_r;
  logic [IDX_W-1:0]                             idx_nxt;
  logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] digits_r;
  logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] digits_nxt;
  logic                                         out_valid_r;
  logic                                         out_valid_nxt;
  logic [b2da_pkg::CHAR_W-1:0]                  out_char_r;
  logic [b2da_pkg::CHAR_W-1:0]                  out_char_nxt;
  logic                                         out_last_r;
  logic                                         out_last_nxt;

  logic                                         out_free;
  logic                                         load;
  logic [IDX_W-1:0]                             top;

  // Highest nonzero position; position 0 is always sent.
  always_comb begin
    top = '0;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (in_digits[i] != '0) begin
        top = IDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;
  // A new digit set is taken while the last character of the previous one
  // moves into the output register, so runs follow without a gap.
  assign load     = in_valid && (!busy_r || (out_free && (idx_r == '0)));
  assign in_ready = load;

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    digits_nxt    = digits_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_char_nxt = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits_r[idx_r]);
        out_last_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end
    if (load) begin
      digits_nxt = in_digits;
      idx_nxt    = top;
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    digits_r   <= digits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/binary_to_decimal_ascii_top.sv =====
// Binary to decimal ASCII converter.
//
// The input channel (in_*) takes one unsigned 16-bit value per item on
// in_tdata. The result channel (out_*) returns its decimal text, most
// significant digit first, one ASCII character per item; leading zeros are
// dropped, so zero gives the single character '0'. out_tlast marks the
// least significant digit, which ends the run of one to five characters.
//
// Each value runs through a pipeline of MAX_DIGITS digit stages, one stage
// per decimal position, each a reciprocal multiply by one tenth. A
// serializer then sends the digits. A value reaches the output through the
// digit stages, the serializer's digit register and its output register.
// The serializer sends one character per cycle while out_tready is high, so
// a value with n digits, up to five, puts n characters on the result channel;
// values may enter back to back and wait in the stages meanwhile.
//
// Reset (rst_n low at a clock edge) empties the pipeline and the output
// register. When the receiver holds out_tready low, the character on the
// output stays put, the whole digit pipeline holds, and in_tready falls as
// soon as the first stage cannot move on; nothing is lost or repeated.
module binary_to_decimal_ascii_top #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [b2da_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [b2da_pkg::OUT_DATA_W-1:0]     out_tdata,  // [5:0] ascii_char, [7:6] zero
  output logic                                out_tlast   // last_char
);

  typedef logic [MAX_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] digits_t;

  // Stage k gets its inputs from entry k; entry 0 is the input port.
  logic [MAX_DIGITS:0]           stg_valid;
  logic [b2da_pkg::VALUE_W-1:0]  stg_rest [MAX_DIGITS];
  digits_t                       stg_digits [MAX_DIGITS+1];

  logic                          advance;
  logic                          ser_ready;
  logic [b2da_pkg::CHAR_W-1:0]   out_char;

  // The digit stages move together; a stage holding nothing never blocks.
  assign advance   = !stg_valid[MAX_DIGITS] || ser_ready;
  assign in_tready = advance;

  assign stg_valid[0]  = in_tvalid;
  assign stg_rest[0]   = in_tdata[b2da_pkg::VALUE_W-1:0];
  assign stg_digits[0] = '0;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_stage
    if (k < MAX_DIGITS - 1) begin : g_mid
      b2da_digit_stage #(
        .MAX_DIGITS (MAX_DIGITS),
        .POS        (k)
      ) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (stg_valid[k]),
        .in_rest    (stg_rest[k]),
        .in_digits  (stg_digits[k]),
        .out_valid  (stg_valid[k+1]),
        .out_rest   (stg_rest[k+1]),
        .out_digits (stg_digits[k+1])
      );
    end else begin : g_last
      // The quotient after the top position is not needed.
      b2da_digit_stage #(
        .MAX_DIGITS (MAX_DIGITS),
        .POS        (k)
      ) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (stg_valid[k]),
        .in_rest    (stg_rest[k]),
        .in_digits  (stg_digits[k]),
        .out_valid  (stg_valid[k+1]),
        .out_rest   (),
        .out_digits (stg_digits[k+1])
      );
    end
  end

  b2da_serializer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[MAX_DIGITS]),
    .in_digits  (stg_digits[MAX_DIGITS]),
    .in_ready   (ser_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = b2da_pkg::OUT_DATA_W'(out_char);

endmodule

// ===== src/b2da_checker.sv =====
module b2da_assertions (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [b2da_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  localparam int CNT_W = $clog2(b2da_pkg::MAX_RESULTS + 1);

  logic             run_start_r;
  logic [CNT_W-1:0] run_cnt_r;
  logic             out_fire;

  assign out_fire = out_tvalid && out_tready;

  // Track where a run of characters begins and how long it has grown.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_start_r <= 1'b1;
      run_cnt_r   <= '0;
    end else if (out_fire) begin
      run_start_r <= out_tlast;
      run_cnt_r   <= out_tlast ? '0 : run_cnt_r + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:6] == 2'b00 &&
                   out_tdata[5:0] >= b2da_pkg::ASCII_ZERO &&
                   out_tdata[5:0] <= b2da_pkg::ASCII_NINE)
    else $error("result is not a decimal digit character");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && run_start_r && !out_tlast |-> out_tdata[5:0] != b2da_pkg::ASCII_ZERO)
    else $error("leading zero sent");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && run_cnt_r == CNT_W'(b2da_pkg::MAX_RESULTS - 1) |-> out_tlast)
    else $error("run longer than five characters");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind binary_to_decimal_ascii_top b2da_assertions u_b2da_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
